// File: hdl/bitmap_text_glyph_rasterizer_macros.svh
// Assertion macros for the 3x5 text rasteriser.
// No dependencies; taken in by the top level only.
`ifndef BITMAP_TEXT_GLYPH_RASTERIZER_MACROS_SVH
`define BITMAP_TEXT_GLYPH_RASTERIZER_MACROS_SVH

// a in this cycle implies b in the same cycle
`define BTGR_ASSERT_NOW(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// a in this cycle implies b in the next cycle
`define BTGR_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

// File: hdl/btgr_pkg.sv
// Shared types, constants, glyph ROM and class table of the 3x5 text rasteriser.
// No dependencies.
`default_nettype none

package btgr_pkg;

	localparam int GLYPH_COUNT = 96;
	localparam logic [7:0] FIRST_CODE = 8'd32;
	localparam int GLYPH_W = 3;
	localparam int GLYPH_H = 5;
	localparam int MASK_BITS = GLYPH_W * GLYPH_H;
	localparam int GIDX_BITS = $clog2(GLYPH_COUNT);
	localparam logic [23:0] COLOUR_RESET = 24'hFFFFFF;
	// descriptor bits that do not depend on the coordinate width
	localparam int DESC_FIXED_BITS = MASK_BITS + 24 + 12;

	typedef enum logic [7:0] {
		REG_KERN_TRIM    = 8'd0,
		REG_MEASURE_ONLY = 8'd1,
		REG_CLASSIFY     = 8'd2,
		REG_PLAIN        = 8'd3,
		REG_LETTER       = 8'd4,
		REG_DIGIT        = 8'd5,
		REG_SYMBOL       = 8'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CLS_SYMBOL,
		CLS_LETTER,
		CLS_DIGIT
	} cls_kind_t;

	typedef struct packed {
		cls_kind_t kind;
		logic      drop;
	} glyph_class_t;

	typedef struct packed {
		logic        kern_trim;
		logic        measure_only;
		logic        classify_colours;
		logic [23:0] plain_colour;
		logic [23:0] letter_colour;
		logic [23:0] digit_colour;
		logic [23:0] symbol_colour;
	} cfg_t;

	typedef struct packed {
		logic [7:0]        char_code;
		logic              first_of_string;
		logic signed [11:0] start_x;
		logic signed [11:0] start_y;
	} in_item_t;

	typedef struct packed {
		logic               is_pixel;
		logic signed [11:0] pixel_x;
		logic signed [11:0] pixel_y;
		logic [23:0]        pixel_colour;
		logic signed [11:0] string_width;
		logic               last;
	} out_item_t;

	// one octal digit per row, top row first; bit 2 of a row is the left column
	localparam logic [MASK_BITS-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
		15'o00000, 15'o22202, 15'o55000, 15'o57575, 15'o76737, 15'o51245, 15'o25253, 15'o12000,
		15'o12221, 15'o21112, 15'o52725, 15'o02720, 15'o00012, 15'o00300, 15'o00002, 15'o11244,
		15'o75557, 15'o26222, 15'o71747, 15'o71717, 15'o55711, 15'o74717, 15'o74757, 15'o71111,
		15'o75757, 15'o75717, 15'o02020, 15'o01012, 15'o12421, 15'o07070, 15'o42124, 15'o61202,
		15'o75747, 15'o25755, 15'o65656, 15'o34443, 15'o65556, 15'o74647, 15'o74644, 15'o34553,
		15'o55755, 15'o72227, 15'o11152, 15'o55655, 15'o44447, 15'o57755, 15'o57775, 15'o25552,
		15'o65644, 15'o25563, 15'o65655, 15'o34216, 15'o72222, 15'o55557, 15'o55552, 15'o55775,
		15'o55255, 15'o55222, 15'o71247, 15'o32223, 15'o44211, 15'o31113, 15'o25000, 15'o00007,
		15'o00300, 15'o03553, 15'o47557, 15'o07447, 15'o17557, 15'o07567, 15'o34744, 15'o75716,
		15'o44755, 15'o02022, 15'o20226, 15'o44565, 15'o22222, 15'o05755, 15'o06555, 15'o07557,
		15'o75744, 15'o75711, 15'o03222, 15'o07617, 15'o47443, 15'o05557, 15'o05552, 15'o05575,
		15'o05225, 15'o55713, 15'o07127, 15'o32623, 15'o22222, 15'o62326, 15'o00700, 15'o72727
	};

	function automatic glyph_class_t glyph_class(input logic [GIDX_BITS-1:0] g);
		glyph_class_t c;
		c.kind = CLS_SYMBOL;
		if (g inside {[7'd16:7'd25]})
			c.kind = CLS_DIGIT;
		else if (g inside {[7'd33:7'd58], 7'd63, [7'd65:7'd90]})
			c.kind = CLS_LETTER;
		// descender letters g j p q y sit one row lower
		c.drop = (g inside {7'd71, 7'd74, 7'd80, 7'd81, 7'd89});
		return c;
	endfunction

endpackage

`default_nettype wire

// File: hdl/btgr_front.sv
// Front end: accepts characters, looks up glyph and class, keeps the cursor.
// Depends on btgr_pkg.
`default_nettype none

module btgr_front #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire btgr_pkg::in_item_t  in_item,
	input  wire btgr_pkg::cfg_t      cfg,
	input  wire logic                q_full,
	output logic                     q_push,
	output logic [btgr_pkg::DESC_FIXED_BITS+2*COORD_BITS-1:0] q_data
);

	localparam int W = COORD_BITS;

	typedef struct packed {
		logic [btgr_pkg::MASK_BITS-1:0] mask;
		logic [23:0]                    colour;
		logic [W-1:0]                   x0;
		logic [W-1:0]                   top;
		logic [11:0]                    width;
	} desc_t;

	logic [W-1:0] cursor_q, origin_q, base_q;
	logic [W-1:0] cur_x, org_x, base_y, kern_x, next_x, diff;
	logic [btgr_pkg::GIDX_BITS-1:0] g;
	logic [btgr_pkg::MASK_BITS-1:0] bits;
	btgr_pkg::glyph_class_t cls;
	logic first_empty, last_empty;
	desc_t desc;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		if (in_item.char_code >= btgr_pkg::FIRST_CODE &&
				in_item.char_code < btgr_pkg::FIRST_CODE + 8'(btgr_pkg::GLYPH_COUNT))
			g = btgr_pkg::GIDX_BITS'(in_item.char_code - btgr_pkg::FIRST_CODE);
		else
			g = '0;
		bits = btgr_pkg::GLYPH_ROM[g];
		cls  = btgr_pkg::glyph_class(g);
		first_empty = !(bits[14] | bits[11] | bits[8] | bits[5] | bits[2]);
		last_empty  = !(bits[12] | bits[9] | bits[6] | bits[3] | bits[0]);

		if (in_item.first_of_string) begin
			cur_x  = W'(in_item.start_x);
			org_x  = W'(in_item.start_x);
			base_y = W'(in_item.start_y);
		end else begin
			cur_x  = cursor_q;
			org_x  = origin_q;
			base_y = base_q;
		end

		kern_x = (cfg.kern_trim && first_empty) ? cur_x - W'(1) : cur_x;
		next_x = kern_x + ((cfg.kern_trim && last_empty) ? W'(3) : W'(4));
		diff   = next_x - org_x;

		desc.mask = cfg.measure_only ? '0 : bits;
		if (!cfg.classify_colours)
			desc.colour = cfg.plain_colour;
		else if (cls.kind == btgr_pkg::CLS_LETTER)
			desc.colour = cfg.letter_colour;
		else if (cls.kind == btgr_pkg::CLS_DIGIT)
			desc.colour = cfg.digit_colour;
		else
			desc.colour = cfg.symbol_colour;
		desc.x0    = kern_x + W'(2);
		desc.top   = base_y + W'(cls.drop);
		desc.width = 12'(diff);
	end

	assign q_data = desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			origin_q <= '0;
			base_q   <= '0;
		end else if (q_push) begin
			cursor_q <= next_x;
			origin_q <= org_x;
			base_q   <= base_y;
		end
	end

endmodule

`default_nettype wire

// File: hdl/btgr_queue.sv
// Two-entry queue between front and back end.
// No package dependencies.
`default_nettype none

module btgr_queue #(
	parameter int WIDTH = 87
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  q_valid,
	output logic [WIDTH-1:0]      q_data
);

	logic [WIDTH-1:0] entry_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

`default_nettype wire

// File: hdl/btgr_back.sv
// Back end: walks the lit pixels of one glyph, then the closing item.
// Depends on btgr_pkg.
`default_nettype none

module btgr_back #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_valid,
	input  wire logic [btgr_pkg::DESC_FIXED_BITS+2*COORD_BITS-1:0] q_data,
	output logic                      q_pop,
	output logic                      busy,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output btgr_pkg::out_item_t       out_item
);

	localparam int W = COORD_BITS;

	typedef struct packed {
		logic [btgr_pkg::MASK_BITS-1:0] mask;
		logic [23:0]                    colour;
		logic [W-1:0]                   x0;
		logic [W-1:0]                   top;
		logic [11:0]                    width;
	} desc_t;

	desc_t cur_q;
	logic  cur_v_q;
	logic  out_valid_q;
	btgr_pkg::out_item_t out_q;

	logic adv, has_pix, found;
	logic [2:0] row;
	logic [1:0] col;
	logic [2:0] row_bits;
	logic [3:0] bit_idx;
	logic [W-1:0] px, py;

	assign adv     = !out_valid_q || !out_stall;
	assign has_pix = cur_v_q && (cur_q.mask != '0);
	assign q_pop   = adv && (!cur_v_q || !has_pix) && q_valid;
	assign busy    = cur_v_q;

	// first lit pixel, rows top down, columns left to right
	always_comb begin
		found = 1'b0;
		row   = '0;
		for (int r = 0; r < btgr_pkg::GLYPH_H; r++) begin
			if (!found && cur_q.mask[14-3*r -: 3] != 3'b000) begin
				found = 1'b1;
				row   = 3'(r);
			end
		end
		row_bits = cur_q.mask[4'd14 - 4'(row) * 4'd3 -: 3];
		if (row_bits[2])
			col = 2'd0;
		else if (row_bits[1])
			col = 2'd1;
		else
			col = 2'd2;
		bit_idx = 4'd14 - 4'(row) * 4'd3 - 4'(col);
		px = cur_q.x0 + W'(col);
		py = cur_q.top + W'(row);
	end

	always_ff @(posedge clk) begin
		if (adv && cur_v_q) begin
			if (has_pix) begin
				out_q.is_pixel     <= 1'b1;
				out_q.pixel_x      <= 12'(px);
				out_q.pixel_y      <= 12'(py);
				out_q.pixel_colour <= cur_q.colour;
				out_q.string_width <= '0;
				out_q.last         <= 1'b0;
			end else begin
				out_q.is_pixel     <= 1'b0;
				out_q.pixel_x      <= '0;
				out_q.pixel_y      <= '0;
				out_q.pixel_colour <= '0;
				out_q.string_width <= cur_q.width;
				out_q.last         <= 1'b1;
			end
		end
		if (q_pop)
			cur_q <= q_data;
		else if (adv && has_pix)
			cur_q.mask <= cur_q.mask & ~(btgr_pkg::MASK_BITS'(1) << bit_idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= cur_v_q;
			if (!cur_v_q || !has_pix)
				cur_v_q <= q_valid;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

// File: hdl/bitmap_text_glyph_rasterizer.sv
// 3x5 bitmap text rasteriser, top level: config registers, front, queue, back.
// Depends on btgr_pkg, btgr_front, btgr_queue, btgr_back and the macros header.
//
// Use: send one character per item on the in channel (in_valid / in_stall,
// in_item). The first item of a string sets first_of_string and brings the
// start x and top y. For every lit glyph pixel one pixel item comes out on
// the out channel (out_valid / out_stall, out_item), rows top down, columns
// left to right, then one closing item with last set and the string width.
// Registers are written on cfg_valid with cfg_index and cfg_data; cfg_ready
// is always high, and writes are meant only while the block is idle.
// An accepted item passes the queue entry, the back end's current glyph
// register and the output register. Throughput: one result per cycle while
// out_stall is low, as the back end walks the glyph mask one pixel a cycle;
// a character gives one item per lit pixel (at most 13) plus the closing item.
// The front end takes a new item every cycle while the two-entry queue has
// room, so it runs ahead of the back end.
// Stall: out_stall freezes the output register and the glyph walk; once the
// queue fills, in_stall rises. Reset clears the cursor, origin and base row
// to zero, empties the queue and output, and loads register defaults
// (colours white, flags off). There is no clearing pass.
`default_nettype none
`include "bitmap_text_glyph_rasterizer_macros.svh"

module bitmap_text_glyph_rasterizer #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// character items
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire btgr_pkg::in_item_t  in_item,
	// pixel and closing items
	output logic                     out_valid,
	input  wire logic                out_stall,
	output btgr_pkg::out_item_t      out_item,
	// register writes
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [7:0]          cfg_index,
	input  wire logic [23:0]         cfg_data
);

	localparam int DESC_BITS = btgr_pkg::DESC_FIXED_BITS + 2 * COORD_BITS;

	btgr_pkg::cfg_t cfg_q;

	logic                 q_push, q_full, q_pop, q_valid, back_busy;
	logic [DESC_BITS-1:0] push_data, q_data;

	// register file; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kern_trim        <= 1'b0;
			cfg_q.measure_only     <= 1'b0;
			cfg_q.classify_colours <= 1'b0;
			cfg_q.plain_colour     <= btgr_pkg::COLOUR_RESET;
			cfg_q.letter_colour    <= btgr_pkg::COLOUR_RESET;
			cfg_q.digit_colour     <= btgr_pkg::COLOUR_RESET;
			cfg_q.symbol_colour    <= btgr_pkg::COLOUR_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				btgr_pkg::REG_KERN_TRIM:    cfg_q.kern_trim        <= cfg_data[0];
				btgr_pkg::REG_MEASURE_ONLY: cfg_q.measure_only     <= cfg_data[0];
				btgr_pkg::REG_CLASSIFY:     cfg_q.classify_colours <= cfg_data[0];
				btgr_pkg::REG_PLAIN:        cfg_q.plain_colour     <= cfg_data;
				btgr_pkg::REG_LETTER:       cfg_q.letter_colour    <= cfg_data;
				btgr_pkg::REG_DIGIT:        cfg_q.digit_colour     <= cfg_data;
				btgr_pkg::REG_SYMBOL:       cfg_q.symbol_colour    <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: classify, kern and advance the cursor, one item a cycle while the queue has room
	btgr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (push_data)
	);

	// decouples the front from output stalls
	btgr_queue #(
		.WIDTH(DESC_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.q_valid   (q_valid),
		.q_data    (q_data)
	);

	// back: pixel walk plus closing item, registered output
	btgr_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.busy      (back_busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// a result is either a pixel or the closing item, never both
	`BTGR_ASSERT_NOW(a_pix_xor_last, clk, arst_n, out_valid, out_item.is_pixel != out_item.last, "pixel and last flags disagree")
	// an accepted item is held in the queue or already in the back end
	`BTGR_ASSERT_NEXT(a_item_kept, clk, arst_n, in_valid && !in_stall, q_valid || back_busy, "accepted item lost")
	// the queue never pops when empty
	`BTGR_ASSERT_NOW(a_pop_nonempty, clk, arst_n, q_pop, q_valid, "pop from empty queue")

endmodule

`default_nettype wire
